@@ design/mbrs_pkg.sv @@
package mbrs_pkg;

  // Register file geometry and its power-up contents.
  localparam int RF_DEPTH       = 8;
  localparam int DISTANCE_INDEX = 2;
  localparam logic [15:0] DISTANCE_RESET = 16'd1000;
  localparam int RF_AW = (RF_DEPTH > 1) ? $clog2(RF_DEPTH) : 1;

  // Frame capture window and protocol limits.
  localparam int FRAME_DEPTH = 12;
  localparam int HDR_LEN     = 6;
  localparam int MIN_LEN     = 2;
  localparam int MAX_LEN     = 253;
  localparam int MAX_READ    = 125;
  localparam int MIN_PDU_LEN = 6;

  // Response sizes: header plus function and code, and the write echo.
  localparam int RESP_BASE  = 9;
  localparam int RESP_WRITE = 12;
  localparam int RESP_MAX   = RESP_BASE + 2 * RF_DEPTH + 4;
  localparam int RESP_W     = $clog2(RESP_MAX + 1);

  // Command codes of an input transaction.
  localparam logic CMD_NET   = 1'b0;
  localparam logic CMD_LOCAL = 1'b1;

  // Function and exception codes.
  localparam logic [7:0] FC_READ     = 8'h03;
  localparam logic [7:0] FC_WRITE    = 8'h06;
  localparam logic [7:0] EXC_FLAG    = 8'h80;
  localparam logic [7:0] EXC_READ    = 8'h83;
  localparam logic [7:0] EXC_WRITE   = 8'h86;
  localparam logic [7:0] EXC_FUNC    = 8'h01;
  localparam logic [7:0] EXC_ADDRESS = 8'h02;
  localparam logic [7:0] EXC_VALUE   = 8'h03;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  rx_byte;
    logic [2:0]  local_addr;
    logic [15:0] local_value;
  } req_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
  } rsp_t;

  // Value an entry holds before anything has written it.
  function automatic logic [15:0] rf_reset_value(input logic [RF_AW-1:0] addr);
    logic [15:0] v;
    v = 16'd0;
    if (32'(addr) == DISTANCE_INDEX) begin
      v = DISTANCE_RESET;
    end
    return v;
  endfunction

endpackage

@@ design/modbus_tcp_register_server.sv @@
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  mbrs_pkg::req_t (cmd, rx_byte, local_addr, ...)
// rsp       out        rsp_valid / rsp_stall  mbrs_pkg::rsp_t (tx_byte, last)
//
// A local write is done while idle. A received byte is stored in idle, then passes the header
// check; when it completes a frame, decode follows, after which the response is sent at one
// byte per cycle while rsp_stall allows, with a wait state between consecutive registers of a
// read, set by the register file's registered read port: 9 bytes for an exception, 12 for a
// write, 9 + 2*count for a read. A short frame of a known function ends at decode.
// Synchronous reset clears the byte count, the sequencer, the output register and the
// register file's written flags, so every register reads its power-up value at once.
// req_stall is high in every cycle outside idle: header check, decode and the response;
// rsp_stall holds the output register and the sequencer waits behind it.
module modbus_tcp_register_server (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  mbrs_pkg::req_t req_data,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output mbrs_pkg::rsp_t rsp_data
);
  import mbrs_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_EMIT   = 3'd3;
  localparam logic [2:0] S_WAIT   = 3'd4;

  logic [2:0] state;

  // Frame capture registers and receive count.
  logic [7:0] frame [FRAME_DEPTH];
  logic [8:0] byte_count;

  // Register file memory, its written flags and registered read port.
  logic [15:0]      rf_mem [RF_DEPTH];
  logic             rf_written [RF_DEPTH];
  logic [15:0]      rf_q;
  logic             rf_written_q;
  logic [RF_AW-1:0] rf_addr_q;
  logic [RF_AW-1:0] rd_addr;
  logic [15:0]      rd_word;

  // Response descriptor latched at decode.
  logic [7:0]        resp_fc;
  logic [7:0]        resp_code;
  logic [RESP_W-1:0] resp_n;
  logic              rd_mode;
  logic [RESP_W-1:0] emit_idx;

  logic        req_fire;
  logic [15:0] hdr_len;
  logic        hdr_ok;
  logic        frame_done;
  logic [7:0]  fc;
  logic [15:0] addr_a;
  logic [15:0] val_b;
  logic [16:0] sum_ab;
  logic        short_frame;

  logic [7:0]        dec_fc;
  logic [7:0]        dec_code;
  logic [RESP_W-1:0] dec_n;
  logic              dec_read;
  logic              dec_write;

  logic              push;
  logic              emit_last;
  logic [7:0]        emit_byte;
  logic [15:0]       pdu_len;

  logic              wr_en;
  logic [RF_AW-1:0]  wr_addr;
  logic [15:0]       wr_data;

  assign req_stall = (state != S_IDLE);
  assign req_fire  = req_valid && !req_stall;

  // Header window checks on the captured bytes.
  assign hdr_len    = {frame[4], frame[5]};
  assign hdr_ok     = (frame[2] == 8'h00) && (frame[3] == 8'h00) &&
                      (hdr_len >= 16'(MIN_LEN)) && (hdr_len <= 16'(MAX_LEN));
  assign frame_done = (byte_count >= 9'(HDR_LEN)) &&
                      ({8'h00, byte_count} >= (17'(HDR_LEN) + {1'b0, hdr_len}));

  assign fc          = frame[7];
  assign addr_a      = {frame[8], frame[9]};
  assign val_b       = {frame[10], frame[11]};
  assign sum_ab      = {1'b0, addr_a} + {1'b0, val_b};
  assign short_frame = ((fc == FC_READ) || (fc == FC_WRITE)) &&
                       (hdr_len < 16'(MIN_PDU_LEN));

  // Request decode: pick the response kind and its length.
  always_comb begin
    dec_fc    = fc | EXC_FLAG;
    dec_code  = EXC_FUNC;
    dec_n     = RESP_W'(RESP_BASE);
    dec_read  = 1'b0;
    dec_write = 1'b0;
    if (fc == FC_READ) begin
      if ((val_b == 16'd0) || (val_b > 16'(MAX_READ))) begin
        dec_fc   = EXC_READ;
        dec_code = EXC_VALUE;
      end else if (sum_ab > 17'(RF_DEPTH)) begin
        dec_fc   = EXC_READ;
        dec_code = EXC_ADDRESS;
      end else begin
        dec_fc   = FC_READ;
        dec_code = {val_b[6:0], 1'b0};
        dec_n    = RESP_W'(RESP_BASE) + (RESP_W'(val_b) << 1);
        dec_read = 1'b1;
      end
    end else if (fc == FC_WRITE) begin
      if (addr_a >= 16'(RF_DEPTH)) begin
        dec_fc   = EXC_WRITE;
        dec_code = EXC_ADDRESS;
      end else begin
        dec_fc    = FC_WRITE;
        dec_code  = frame[8];
        dec_n     = RESP_W'(RESP_WRITE);
        dec_write = 1'b1;
      end
    end
  end

  // Single write port: local writes while idle, function 6 writes at decode.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = RF_AW'(req_data.local_addr);
    wr_data = req_data.local_value;
    if (req_fire && (req_data.cmd == CMD_LOCAL) &&
        (32'(req_data.local_addr) < RF_DEPTH)) begin
      wr_en = 1'b1;
    end else if ((state == S_DECODE) && !short_frame && dec_write) begin
      wr_en   = 1'b1;
      wr_addr = RF_AW'(addr_a);
      wr_data = val_b;
    end
  end

  // Register file memory with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rf_mem[wr_addr] <= wr_data;
    end
    rf_q      <= rf_mem[rd_addr];
    rf_addr_q <= rd_addr;
  end

  // Written flags: an unwritten entry reads as its power-up value.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RF_DEPTH; i++) begin
        rf_written[i] <= 1'b0;
      end
      rf_written_q <= 1'b0;
    end else begin
      if (wr_en) begin
        rf_written[wr_addr] <= 1'b1;
      end
      rf_written_q <= rf_written[rd_addr];
    end
  end

  assign rd_word = rf_written_q ? rf_q : rf_reset_value(rf_addr_q);

  // Response byte selection.
  assign pdu_len   = 16'(resp_n) - 16'(HDR_LEN);
  assign emit_last = (emit_idx == (resp_n - RESP_W'(1)));

  always_comb begin
    if (emit_idx < RESP_W'(4)) begin
      emit_byte = frame[{2'b00, emit_idx[1:0]}];
    end else if (emit_idx == RESP_W'(4)) begin
      emit_byte = pdu_len[15:8];
    end else if (emit_idx == RESP_W'(5)) begin
      emit_byte = pdu_len[7:0];
    end else if (emit_idx == RESP_W'(6)) begin
      emit_byte = frame[6];
    end else if (emit_idx == RESP_W'(7)) begin
      emit_byte = resp_fc;
    end else if (emit_idx == RESP_W'(8)) begin
      emit_byte = resp_code;
    end else if (rd_mode) begin
      emit_byte = emit_idx[0] ? rd_word[15:8] : rd_word[7:0];
    end else begin
      emit_byte = frame[emit_idx[3:0]];
    end
  end

  assign push = (state == S_EMIT) && (!rsp_valid || !rsp_stall);

  // Frame capture registers: store, and shift by one on a bad header.
  always_ff @(posedge clk) begin
    if (req_fire && (req_data.cmd == CMD_NET) && (byte_count < 9'(FRAME_DEPTH))) begin
      frame[byte_count[3:0]] <= req_data.rx_byte;
    end else if ((state == S_CHECK) && (byte_count == 9'(HDR_LEN)) && !hdr_ok) begin
      for (int i = 0; i < HDR_LEN - 1; i++) begin
        frame[i] <= frame[i + 1];
      end
    end
  end

  // Response descriptor and read address.
  always_ff @(posedge clk) begin
    if (state == S_DECODE) begin
      resp_fc   <= dec_fc;
      resp_code <= dec_code;
      resp_n    <= dec_n;
      rd_addr   <= RF_AW'(addr_a);
    end else if (push && rd_mode && (emit_idx >= RESP_W'(10)) && !emit_idx[0]) begin
      rd_addr <= rd_addr + RF_AW'(1);
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      byte_count <= 9'd0;
      rd_mode    <= 1'b0;
      emit_idx   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_fire && (req_data.cmd == CMD_NET)) begin
            byte_count <= byte_count + 9'd1;
            state      <= S_CHECK;
          end
        end
        S_CHECK: begin
          if ((byte_count == 9'(HDR_LEN)) && !hdr_ok) begin
            byte_count <= 9'(HDR_LEN - 1);
            state      <= S_IDLE;
          end else if (frame_done) begin
            byte_count <= 9'd0;
            state      <= S_DECODE;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DECODE: begin
          emit_idx <= '0;
          rd_mode  <= dec_read;
          state    <= short_frame ? S_IDLE : S_EMIT;
        end
        S_EMIT: begin
          if (push) begin
            emit_idx <= emit_idx + RESP_W'(1);
            if (emit_last) begin
              state <= S_IDLE;
            end else if (rd_mode && (emit_idx >= RESP_W'(10)) && !emit_idx[0]) begin
              state <= S_WAIT;
            end
          end
        end
        S_WAIT: begin
          state <= S_EMIT;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (push) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      rsp_data.tx_byte <= emit_byte;
      rsp_data.last    <= emit_last;
    end
  end

  // The receive count never runs past the longest legal frame.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= 9'(HDR_LEN + MAX_LEN))
    else $error("byte count beyond longest frame");

  // The emit index stays inside the response.
  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (emit_idx < resp_n))
    else $error("emit index past response length");

  // Register writes come only from a local write or a decoded function 6.
  a_write_src: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> ((state == S_IDLE) || (state == S_DECODE)))
    else $error("register write outside idle or decode");

  // Sending the final byte returns the sequencer to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (push && emit_last) |=> (state == S_IDLE))
    else $error("sequencer busy after final byte");

  // A read-ahead wait returns to emit in the cycle after it.
  a_wait_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT) |=> (state == S_EMIT))
    else $error("read wait did not return to emit");

endmodule

@@ tb/sv/modbus_response_checker.sv @@
// Watches both channels of the register server, predicts every response byte
// from the accepted request transactions and compares the bytes as they leave.
module modbus_response_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_stall,
  input  mbrs_pkg::req_t req_data,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  mbrs_pkg::rsp_t rsp_data,
  output int unsigned    mismatches,
  output int unsigned    pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import mbrs_pkg::*;

  // Predicted server state: capture window, byte count and holding registers.
  logic [7:0]  frame_q [FRAME_DEPTH];
  int          rx_count;
  logic [15:0] holding [RF_DEPTH];
  rsp_t        response_bytes_due [$];
  int unsigned errors = 0;

  function automatic int unsigned frame_len();
    return 32'({frame_q[4], frame_q[5]});
  endfunction

  function automatic bit header_ok();
    int unsigned len;
    len = frame_len();
    if (frame_q[2] != 8'h00 || frame_q[3] != 8'h00) begin
      return 1'b0;
    end
    return len >= MIN_LEN && len <= MAX_LEN;
  endfunction

  // Builds the answer to the frame in the window and queues its bytes.
  task automatic answer_frame();
    logic [7:0]  resp [RESP_MAX];
    logic [7:0]  fc;
    int unsigned len;
    int unsigned a;
    int unsigned b;
    int          n;
    rsp_t        item;
    len = frame_len();
    fc  = frame_q[7];
    for (int k = 0; k < 4; k++) begin
      resp[k] = frame_q[k];
    end
    resp[6] = frame_q[6];
    a = 0;
    b = 0;
    if (fc == FC_READ || fc == FC_WRITE) begin
      // Too short to carry address and count: dropped without a reply.
      if (len < MIN_PDU_LEN) begin
        return;
      end
      a = 32'({frame_q[8], frame_q[9]});
      b = 32'({frame_q[10], frame_q[11]});
    end
    n = RESP_BASE;
    if (fc == FC_READ) begin
      if (b == 0 || b > MAX_READ) begin
        resp[7] = EXC_READ;
        resp[8] = EXC_VALUE;
      end else if (a + b > RF_DEPTH) begin
        resp[7] = EXC_READ;
        resp[8] = EXC_ADDRESS;
      end else begin
        resp[7] = FC_READ;
        resp[8] = 8'(b * 2);
        for (int unsigned i = 0; i < b; i++) begin
          resp[n]     = holding[a + i][15:8];
          resp[n + 1] = holding[a + i][7:0];
          n += 2;
        end
      end
    end else if (fc == FC_WRITE) begin
      if (a >= RF_DEPTH) begin
        resp[7] = EXC_WRITE;
        resp[8] = EXC_ADDRESS;
      end else begin
        holding[a] = 16'(b);
        resp[7] = FC_WRITE;
        for (int k = 8; k < RESP_WRITE; k++) begin
          resp[k] = frame_q[k];
        end
        n = RESP_WRITE;
      end
    end else begin
      resp[7] = fc | EXC_FLAG;
      resp[8] = EXC_FUNC;
    end
    resp[4] = 8'((n - HDR_LEN) >> 8);
    resp[5] = 8'(n - HDR_LEN);
    for (int k = 0; k < n; k++) begin
      item.tx_byte = resp[k];
      item.last    = (k == n - 1);
      response_bytes_due = {response_bytes_due, item};
    end
  endtask

  // Applies one request transaction to the predicted state.
  task automatic absorb_request(input req_t item);
    if (item.cmd == CMD_LOCAL) begin
      if (int'(item.local_addr) < RF_DEPTH) begin
        holding[item.local_addr] = item.local_value;
      end
      return;
    end
    // Bytes past the capture window are counted but not kept.
    if (rx_count < FRAME_DEPTH) begin
      frame_q[rx_count] = item.rx_byte;
    end
    rx_count++;
    if (rx_count == HDR_LEN && !header_ok()) begin
      // Bad header: slide the window by one byte to resynchronize.
      for (int k = 0; k < HDR_LEN - 1; k++) begin
        frame_q[k] = frame_q[k + 1];
      end
      rx_count = HDR_LEN - 1;
    end else if (rx_count >= HDR_LEN && rx_count >= HDR_LEN + int'(frame_len())) begin
      rx_count = 0;
      answer_frame();
    end
  endtask

  // Samples both channels at each edge; requests are applied before responses.
  always @(posedge clk) begin
    rsp_t due;
    if (rst) begin
      rx_count = 0;
      for (int k = 0; k < FRAME_DEPTH; k++) begin
        frame_q[k] = 8'h00;
      end
      for (int k = 0; k < RF_DEPTH; k++) begin
        holding[k] = (k == DISTANCE_INDEX) ? DISTANCE_RESET : 16'h0000;
      end
      response_bytes_due.delete();
    end else begin
      if (req_valid && !req_stall) begin
        absorb_request(req_data);
      end
      if (rsp_valid && !rsp_stall) begin
        if (response_bytes_due.size() == 0) begin
          if (errors < 10) begin
            $display("unexpected response byte %h last %b", rsp_data.tx_byte, rsp_data.last);
          end
          errors++;
        end else begin
          due = response_bytes_due.pop_front();
          if (rsp_data.tx_byte !== due.tx_byte || rsp_data.last !== due.last) begin
            if (errors < 10) begin
              $display("response mismatch: expected byte %h last %b, got byte %h last %b",
                       due.tx_byte, due.last, rsp_data.tx_byte, rsp_data.last);
            end
            errors++;
          end
        end
      end
    end
    mismatches <= errors;
    pending    <= response_bytes_due.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
// Drives request transactions into the register server, stalls its response
// channel at random and reports the verdict from the response checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mbrs_pkg::*;

  localparam int RANDOM_ITEMS = 310;
  localparam int QUIET_LIMIT  = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req_data = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp_data;
  int unsigned mismatches;
  int unsigned pending;
  int          sent = 0;
  bit          steady = 1'b0;
  int          quiet = 0;

  modbus_tcp_register_server uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  modbus_response_checker response_watch (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_data   (req_data),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp_data   (rsp_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #5ns clk = ~clk;

  // Random back-pressure on the response channel, none during the steady stretch.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= !steady && ($urandom_range(99) < 34);
    end
  end

  // Ends the run when no transaction has completed for too long.
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet == QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offers one request transaction, with random idle cycles ahead of it.
  task automatic put(input req_t item);
    while (!steady && $urandom_range(99) < 34) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= item;
    @(posedge clk);
    while (req_stall) begin
      @(posedge clk);
    end
    sent++;
  endtask

  task automatic put_byte(input logic [7:0] value);
    req_t item;
    item.cmd         = CMD_NET;
    item.rx_byte     = value;
    item.local_addr  = 3'($urandom_range(7));
    item.local_value = 16'($urandom_range(16'hFFFF));
    put(item);
  endtask

  task automatic put_local(input logic [2:0] addr, input logic [15:0] value);
    req_t item;
    item.cmd         = CMD_LOCAL;
    item.rx_byte     = 8'($urandom_range(8'hFF));
    item.local_addr  = addr;
    item.local_value = value;
    put(item);
  endtask

  // Sends a well-formed frame; local writes may slip in between its bytes.
  task automatic send_frame(input logic [15:0] tid, input logic [7:0] unit,
                            input logic [7:0] fc, input logic [15:0] len,
                            input logic [15:0] a, input logic [15:0] b);
    logic [7:0] value;
    for (int k = 0; k < HDR_LEN + int'(len); k++) begin
      if ($urandom_range(99) < 4) begin
        put_local(3'($urandom_range(7)), 16'($urandom_range(16'hFFFF)));
      end
      case (k)
        0:       value = tid[15:8];
        1:       value = tid[7:0];
        2, 3:    value = 8'h00;
        4:       value = len[15:8];
        5:       value = len[7:0];
        6:       value = unit;
        7:       value = fc;
        8:       value = a[15:8];
        9:       value = a[7:0];
        10:      value = b[15:8];
        11:      value = b[7:0];
        default: value = 8'($urandom_range(8'hFF));
      endcase
      put_byte(value);
    end
  endtask

  // Sends a header the server must reject and slide past.
  task automatic send_bad_header();
    logic [15:0] proto;
    logic [15:0] len;
    proto = 16'h0000;
    len   = 16'd6;
    case ($urandom_range(3))
      0: proto = 16'($urandom_range(1, 16'hFFFF));
      1: len = 16'($urandom_range(0, MIN_LEN - 1));
      2: len = $urandom_range(1) ? 16'(MAX_LEN + 1) : 16'($urandom_range(MAX_LEN + 1, 16'hFFFF));
      default: begin
        proto = 16'($urandom_range(1, 16'hFFFF));
        len   = 16'($urandom_range(16'hFFFF));
      end
    endcase
    put_byte(8'($urandom_range(8'hFF)));
    put_byte(8'($urandom_range(8'hFF)));
    put_byte(proto[15:8]);
    put_byte(proto[7:0]);
    put_byte(len[15:8]);
    put_byte(len[7:0]);
  endtask

  initial begin
    int          pick;
    logic [15:0] a;
    logic [15:0] b;
    logic [7:0]  fc;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme local writes, a full-file read and a write echo.
    put_local(3'd7, 16'hFFFF);
    put_local(3'd0, 16'h0000);
    send_frame(16'hFFFF, 8'hFF, FC_READ, 16'(MIN_PDU_LEN), 16'd0, 16'(RF_DEPTH));
    send_frame(16'h0000, 8'h00, FC_WRITE, 16'(MIN_PDU_LEN), 16'd5, 16'h8001);

    // Random: mostly well-formed frames of every kind, some noise and local writes.
    while (sent < RANDOM_ITEMS) begin
      steady = (sent >= 130 && sent < 210);
      pick   = int'($urandom_range(99));
      a      = 16'($urandom_range(16'hFFFF));
      b      = 16'($urandom_range(16'hFFFF));
      if (pick < 30) begin
        a = 16'($urandom_range(RF_DEPTH - 1));
        b = 16'($urandom_range(1, RF_DEPTH - int'(a)));
        send_frame(16'($urandom_range(16'hFFFF)), 8'($urandom_range(8'hFF)), FC_READ,
                   16'(MIN_PDU_LEN), a, b);
      end else if (pick < 38) begin
        // Read count of zero or above the protocol maximum.
        b = $urandom_range(1) ? 16'd0 : 16'($urandom_range(MAX_READ + 1, 16'hFFFF));
        send_frame(16'($urandom_range(16'hFFFF)), 8'($urandom_range(8'hFF)), FC_READ,
                   16'(MIN_PDU_LEN), a, b);
      end else if (pick < 45) begin
        // Read range running off the end of the register file.
        b = 16'($urandom_range(1, MAX_READ));
        if (int'(a) + int'(b) <= RF_DEPTH) begin
          a = 16'(RF_DEPTH);
        end
        send_frame(16'($urandom_range(16'hFFFF)), 8'($urandom_range(8'hFF)), FC_READ,
                   16'(MIN_PDU_LEN), a, b);
      end else if (pick < 65) begin
        a = 16'($urandom_range(RF_DEPTH - 1));
        send_frame(16'($urandom_range(16'hFFFF)), 8'($urandom_range(8'hFF)), FC_WRITE,
                   16'(MIN_PDU_LEN), a, b);
      end else if (pick < 72) begin
        // Write address outside the register file.
        a = 16'($urandom_range(RF_DEPTH, 16'hFFFF));
        send_frame(16'($urandom_range(16'hFFFF)), 8'($urandom_range(8'hFF)), FC_WRITE,
                   16'(MIN_PDU_LEN), a, b);
      end else if (pick < 79) begin
        // Function code the server does not implement.
        fc = 8'($urandom_range(8'hFF));
        while (fc == FC_READ || fc == FC_WRITE) begin
          fc = 8'($urandom_range(8'hFF));
        end
        send_frame(16'($urandom_range(16'hFFFF)), 8'($urandom_range(8'hFF)), fc,
                   16'($urandom_range(MIN_LEN, 8)), a, b);
      end else if (pick < 85) begin
        // Known function in a frame too short to carry its fields.
        fc = $urandom_range(1) ? FC_READ : FC_WRITE;
        send_frame(16'($urandom_range(16'hFFFF)), 8'($urandom_range(8'hFF)), fc,
                   16'($urandom_range(MIN_LEN, MIN_PDU_LEN - 1)), a, b);
      end else if (pick < 90) begin
        // Longer frame whose bytes past the window are counted only.
        fc = $urandom_range(1) ? FC_READ : FC_WRITE;
        a  = 16'($urandom_range(RF_DEPTH - 1));
        b  = (fc == FC_READ) ? 16'($urandom_range(1, RF_DEPTH - int'(a))) : b;
        send_frame(16'($urandom_range(16'hFFFF)), 8'($urandom_range(8'hFF)), fc,
                   16'($urandom_range(MIN_PDU_LEN + 1, 24)), a, b);
      end else if (pick < 95) begin
        send_bad_header();
      end else begin
        repeat ($urandom_range(1, 3)) begin
          put_local(3'($urandom_range(7)), 16'($urandom_range(16'hFFFF)));
        end
      end
    end
    steady = 1'b0;
    req_valid <= 1'b0;

    // Drain every expected response, then watch for stray bytes.
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
